// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, quiet during reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- rtl/bmr_pkg.sv -----
package bmr_pkg;
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_APPLY = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [2:0] REG_FW = 3'd0;
   localparam logic [2:0] REG_FH = 3'd1;
   localparam logic [2:0] REG_RL = 3'd2;
   localparam logic [2:0] REG_RT = 3'd3;
   localparam logic [2:0] REG_RW = 3'd4;
   localparam logic [2:0] REG_RH = 3'd5;
   localparam logic [2:0] REG_BS = 3'd6;

   localparam logic [6:0] BLOCK_RESET = 7'd25;

   typedef struct packed {
      logic [1:0] operation;
      logic [9:0] column;
      logic [8:0] row;
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
   } req_type;

   typedef struct packed {
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
      logic       out_of_range;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic [1:0] op;
      logic       in_frame;
      logic [9:0] column;
      logic [8:0] row;
      logic [23:0] pixel;
   } cmd_type;

   typedef struct packed {
      logic [9:0] fw;
      logic [8:0] fh;
      logic [9:0] rl;
      logic [8:0] rt;
      logic [9:0] rw;
      logic [8:0] rh;
      logic [6:0] bs;
   } cfg_type;
endpackage

// ----- rtl/bmr_front.sv -----
// Accepts request words, checks the address against the frame, queues commands.
module bmr_front #(
   parameter int MAX_WIDTH  = 640,
   parameter int MAX_HEIGHT = 480,
   parameter int DEPTH      = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  bmr_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  bmr_pkg::req_type  req_data,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output bmr_pkg::cmd_type  cmd_data
);
   localparam int AW = $clog2(DEPTH);
   bmr_pkg::cmd_type q_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;
   logic [12:0]   fw_eff, fh_eff;
   bmr_pkg::cmd_type c;

   // frame size clamped to the store
   assign fw_eff = ({3'd0, cfg.fw} > 13'(MAX_WIDTH))  ? 13'(MAX_WIDTH)  : {3'd0, cfg.fw};
   assign fh_eff = ({4'd0, cfg.fh} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, cfg.fh};

   always_comb begin
      c.op       = req_data.operation;
      c.in_frame = ({3'd0, req_data.column} < fw_eff) && ({4'd0, req_data.row} < fh_eff);
      c.column   = req_data.column;
      c.row      = req_data.row;
      c.pixel    = {req_data.red_in, req_data.green_in, req_data.blue_in};
   end

   assign req_stall = (cnt_ff == (AW+1)'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd_data  = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= c;
   end

   `include "assert_macros.svh"
   `CHK_IMPLY(a_no_over, clock, reset, cnt_ff == (AW+1)'(DEPTH), !push, "queue overflow")
   `CHK_NEXT(a_cnt_up, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1, "count slip")
   `CHK_IMPLY(a_no_under, clock, reset, cnt_ff == '0, !pop, "queue underflow")
endmodule

// ----- rtl/bmr_back.sv -----
// Executes commands against the pixel store; apply walks blocks in three passes.
module bmr_back #(
   parameter int MAX_WIDTH  = 640,
   parameter int MAX_HEIGHT = 480,
   parameter int MAX_BLOCK  = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  bmr_pkg::cfg_type  cfg,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  bmr_pkg::cmd_type  cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bmr_pkg::rsp_type  rsp_data
);
   localparam int DEPTHM = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = $clog2(DEPTHM);
   localparam int NW = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
   localparam int SW = NW + 8;
   localparam int BW = $clog2(MAX_BLOCK + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_READ  = 8'b00000010,
      S_BLK   = 8'b00000100,
      S_SUM   = 8'b00001000,
      S_DIV   = 8'b00010000,
      S_FILL  = 8'b00100000,
      S_NEXT  = 8'b01000000,
      S_SDRN  = 8'b10000000
   } st_type;

   logic [23:0] mem [DEPTHM];
   logic [23:0] rd_ff;
   logic        we;
   logic [AW-1:0] waddr, raddr;
   logic [23:0] wdata;

   st_type st_ff, st_in;
   bmr_pkg::rsp_type out_ff, out_in;
   logic out_v_ff, out_v_in;

   logic [12:0] fw, fh, bs;
   logic [12:0] bx_ff, bx_in, by_ff, by_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [12:0] x_ff, x_in, y_ff, y_in;
   logic [NW-1:0] n_ff, n_in;
   logic [SW-1:0] sb_ff, sb_in, sg_ff, sg_in, sr_ff, sr_in;
   logic [SW-1:0] rb_ff, rb_in, rg_ff, rg_in, rr_ff, rr_in;
   logic [7:0] qb_ff, qb_in, qg_ff, qg_in, qr_ff, qr_in;
   logic [3:0] dk_ff, dk_in;
   logic       pend_ff, pend_in;
   logic [12:0] xe, ye;
   logic [AW-1:0] cur_addr;
   logic [SW-1:0] dn, tb, tg, tr;
   logic [7:0] fb, fg, fr;

   assign fw = ({3'd0, cfg.fw} > 13'(MAX_WIDTH))  ? 13'(MAX_WIDTH)  : {3'd0, cfg.fw};
   assign fh = ({4'd0, cfg.fh} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, cfg.fh};
   assign bs = (cfg.bs == '0) ? 13'd1 :
               ({6'd0, cfg.bs} > 13'(MAX_BLOCK)) ? 13'(MAX_BLOCK) : {6'd0, cfg.bs};
   assign xe = {3'd0, cfg.rl} + {3'd0, cfg.rw};
   assign ye = {4'd0, cfg.rt} + {4'd0, cfg.rh};
   assign cur_addr = AW'(y_ff) * AW'(MAX_WIDTH) + AW'(x_ff);

   // final rounding: ties to even
   function automatic logic [7:0] rnd(input logic [7:0] q, input logic [SW-1:0] r,
                                       input logic [SW-1:0] n);
      logic [SW:0] r2;
      r2 = {r, 1'b0};
      if (r2 > {1'b0, n} || (r2 == {1'b0, n} && q[0])) return q + 8'd1;
      return q;
   endfunction

   assign dn = SW'(n_ff);

   // memory port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_comb begin
      st_in = st_ff; out_in = out_ff; out_v_in = out_v_ff;
      bx_in = bx_ff; by_in = by_ff; x1_in = x1_ff; y1_in = y1_ff;
      x_in = x_ff; y_in = y_ff; n_in = n_ff;
      sb_in = sb_ff; sg_in = sg_ff; sr_in = sr_ff;
      rb_in = rb_ff; rg_in = rg_ff; rr_in = rr_ff;
      qb_in = qb_ff; qg_in = qg_ff; qr_in = qr_ff; dk_in = dk_ff;
      pend_in = pend_ff;
      we = 1'b0; waddr = cur_addr; wdata = {qr_ff, qg_ff, qb_ff};
      raddr = cur_addr; cmd_take = 1'b0;
      tb = '0; tg = '0; tr = '0;
      fb = '0; fg = '0; fr = '0;
      if (out_v_ff && !rsp_stall) out_v_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (cmd_valid && !out_v_in) begin
               cmd_take = 1'b1;
               out_in = '0;
               raddr = AW'(cmd_data.row) * AW'(MAX_WIDTH) + AW'(cmd_data.column);
               unique case (cmd_data.op)
                  bmr_pkg::OP_WRITE: begin
                     waddr = raddr; wdata = cmd_data.pixel;
                     we = cmd_data.in_frame;
                     out_in.out_of_range = !cmd_data.in_frame;
                     out_v_in = 1'b1;
                  end
                  bmr_pkg::OP_READ: begin
                     pend_in = cmd_data.in_frame;
                     out_in.out_of_range = !cmd_data.in_frame;
                     st_in = S_READ;
                  end
                  bmr_pkg::OP_APPLY: begin
                     bx_in = {3'd0, cfg.rl}; by_in = {4'd0, cfg.rt};
                     st_in = S_BLK;
                  end
                  default: out_v_in = 1'b1;
               endcase
            end
         end
         S_READ: begin
            // store data for the read address is in rd_ff now
            if (pend_ff) begin
               out_in.blue_out = rd_ff[7:0];
               out_in.green_out = rd_ff[15:8];
               out_in.red_out = rd_ff[23:16];
            end
            out_v_in = 1'b1; st_in = S_IDLE;
         end
         S_BLK: begin
            // set up one block or move on
            if (by_ff >= ye || by_ff >= fh) begin
               out_v_in = 1'b1; out_in = '0; st_in = S_SDRN;
            end else if (bx_ff >= xe || bx_ff >= fw) begin
               bx_in = {3'd0, cfg.rl}; by_in = by_ff + bs;
            end else begin
               x1_in = (bx_ff + bs > fw) ? fw : bx_ff + bs;
               y1_in = (by_ff + bs > fh) ? fh : by_ff + bs;
               x_in = bx_ff; y_in = by_ff;
               sb_in = '0; sg_in = '0; sr_in = '0; n_in = '0;
               pend_in = 1'b0;
               st_in = S_SUM;
            end
         end
         S_SUM: begin
            // address issued now, data lands next cycle
            if (pend_ff) begin
               sb_in = sb_ff + SW'(rd_ff[7:0]);
               sg_in = sg_ff + SW'(rd_ff[15:8]);
               sr_in = sr_ff + SW'(rd_ff[23:16]);
               n_in = n_ff + 1'b1;
            end
            if (y_ff >= y1_ff) begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  rb_in = sb_ff; rg_in = sg_ff; rr_in = sr_ff;
                  qb_in = '0; qg_in = '0; qr_in = '0; dk_in = 4'd7;
                  st_in = S_DIV;
               end
            end else begin
               pend_in = 1'b1;
               if (x_ff + 1'b1 >= x1_ff) begin
                  x_in = bx_ff; y_in = y_ff + 1'b1;
               end else x_in = x_ff + 1'b1;
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            tb = SW'(dn << dk_ff); tg = tb; tr = tb;
            if (rb_ff >= tb && (dn << dk_ff) >> dk_ff == dn) begin
               rb_in = rb_ff - tb; qb_in[dk_ff[2:0]] = 1'b1;
            end
            if (rg_ff >= tg && (dn << dk_ff) >> dk_ff == dn) begin
               rg_in = rg_ff - tg; qg_in[dk_ff[2:0]] = 1'b1;
            end
            if (rr_ff >= tr && (dn << dk_ff) >> dk_ff == dn) begin
               rr_in = rr_ff - tr; qr_in[dk_ff[2:0]] = 1'b1;
            end
            if (dk_ff == '0) begin
               fb = rnd(qb_in, rb_in, dn);
               fg = rnd(qg_in, rg_in, dn);
               fr = rnd(qr_in, rr_in, dn);
               qb_in = fb; qg_in = fg; qr_in = fr;
               x_in = bx_ff; y_in = by_ff;
               st_in = S_FILL;
            end else dk_in = dk_ff - 1'b1;
         end
         S_FILL: begin
            we = 1'b1;
            if (x_ff + 1'b1 >= x1_ff) begin
               x_in = bx_ff;
               if (y_ff + 1'b1 >= y1_ff) st_in = S_NEXT;
               else y_in = y_ff + 1'b1;
            end else x_in = x_ff + 1'b1;
         end
         S_NEXT: begin
            bx_in = bx_ff + bs; st_in = S_BLK;
         end
         S_SDRN: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; out_v_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         st_ff <= st_in; out_v_ff <= out_v_in; pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      bx_ff <= bx_in; by_ff <= by_in; x1_ff <= x1_in; y1_ff <= y1_in;
      x_ff <= x_in; y_ff <= y_in; n_ff <= n_in;
      sb_ff <= sb_in; sg_ff <= sg_in; sr_ff <= sr_in;
      rb_ff <= rb_in; rg_ff <= rg_in; rr_ff <= rr_in;
      qb_ff <= qb_in; qg_ff <= qg_in; qr_ff <= qr_in; dk_ff <= dk_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   `include "assert_macros.svh"
   `CHK_IMPLY(a_one_hot, clock, reset, 1'b1, $onehot(st_ff), "state not one-hot")
   `CHK_NEXT(a_hold, clock, reset, out_v_ff && rsp_stall, out_v_ff && $stable(out_ff),
             "held result changed")
   `CHK_IMPLY(a_take_idle, clock, reset, cmd_take, st_ff == S_IDLE && (!out_v_ff || !rsp_stall),
              "command taken while busy")
endmodule

// ----- rtl/block_mosaic_region_unit.sv -----
// A write result is registered in the cycle after the command leaves the queue head; a read
// passes the store read register, then the result register. Writes are taken one per cycle
// while rsp_stall is low; a read ends before the next command is taken. Apply, per block:
// sum pass, 8-bit restoring divide, fill pass; the store walk and the bit-serial divide set its speed.
// Reset (synchronous): registers to their reset values, queue and results empty;
// pixel store contents undefined until written.
module block_mosaic_region_unit #(
   parameter int MAX_WIDTH  = 640,
   parameter int MAX_HEIGHT = 480,
   parameter int MAX_BLOCK  = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bmr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bmr_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   bmr_pkg::cfg_type cfg_ff, cfg_in;
   logic cmd_valid, cmd_take;
   bmr_pkg::cmd_type cmd_data;
   logic [2:0] ridx;

   assign csr_pready = 1'b1;
   assign ridx = csr_paddr[4:2];

   // register file writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'd0) begin
         unique case (ridx)
            bmr_pkg::REG_FW: cfg_in.fw = csr_pwdata[9:0];
            bmr_pkg::REG_FH: cfg_in.fh = csr_pwdata[8:0];
            bmr_pkg::REG_RL: cfg_in.rl = csr_pwdata[9:0];
            bmr_pkg::REG_RT: cfg_in.rt = csr_pwdata[8:0];
            bmr_pkg::REG_RW: cfg_in.rw = csr_pwdata[9:0];
            bmr_pkg::REG_RH: cfg_in.rh = csr_pwdata[8:0];
            bmr_pkg::REG_BS: cfg_in.bs = csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         bmr_pkg::REG_FW: csr_prdata = {22'd0, cfg_ff.fw};
         bmr_pkg::REG_FH: csr_prdata = {23'd0, cfg_ff.fh};
         bmr_pkg::REG_RL: csr_prdata = {22'd0, cfg_ff.rl};
         bmr_pkg::REG_RT: csr_prdata = {23'd0, cfg_ff.rt};
         bmr_pkg::REG_RW: csr_prdata = {22'd0, cfg_ff.rw};
         bmr_pkg::REG_RH: csr_prdata = {23'd0, cfg_ff.rh};
         bmr_pkg::REG_BS: csr_prdata = {25'd0, cfg_ff.bs};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fw <= 10'd640; cfg_ff.fh <= 9'd480;
         cfg_ff.rl <= '0; cfg_ff.rt <= '0; cfg_ff.rw <= '0; cfg_ff.rh <= '0;
         cfg_ff.bs <= bmr_pkg::BLOCK_RESET;
      end else cfg_ff <= cfg_in;
   end

   bmr_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock, .reset, .cfg(cfg_ff), .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_take, .cmd_data);

   bmr_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_BLOCK(MAX_BLOCK)) u_back (
      .clock, .reset, .cfg(cfg_ff), .cmd_valid, .cmd_take, .cmd_data,
      .rsp_valid, .rsp_stall, .rsp_data);
endmodule
